### hdl/iecd_pkg.sv
// Shared types and constants for the IEC 104 APCI deframer.
// Used by every module in hdl; depends on nothing.
package iecd_pkg;

   localparam int HEADER_BYTES       = 6;
   localparam int FIFO_DEPTH_DEFAULT = 8;
   localparam int SEQ_W              = 15;

   localparam logic [7:0] START_BYTE      = 8'h68;
   localparam logic [7:0] MIN_LENGTH      = 8'd4;
   localparam logic [7:0] MAX_LENGTH_INIT = 8'd253;

   typedef enum logic [1:0] {
      REQ_BYTE    = 2'd0,
      REQ_STAMP_I = 2'd1,
      REQ_STAMP_S = 2'd2
   } req_code_type;

   typedef enum logic [1:0] {
      KIND_U   = 2'd0,
      KIND_S   = 2'd1,
      KIND_I   = 2'd2,
      KIND_BAD = 2'd3
   } frame_kind_type;

   typedef enum logic [2:0] {
      PH_HUNT = 3'd0,
      PH_LEN  = 3'd1,
      PH_HDR  = 3'd2,
      PH_PASS = 3'd3,
      PH_SKIP = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      ENTRY_BYTE   = 2'd0,
      ENTRY_HEADER = 2'd1,
      ENTRY_STAMP  = 2'd2
   } entry_op_type;

   typedef struct packed {
      entry_op_type           op;
      logic [8*HEADER_BYTES-1:0] data;
      frame_kind_type         kind;
      logic                   last;
      logic [SEQ_W-1:0]       send_seq;
      logic [SEQ_W-1:0]       recv_seq;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   function automatic frame_kind_type classify(input logic [7:0] ctl0,
                                               input logic [7:0] ctl2,
                                               input logic [7:0] len);
      frame_kind_type k;
      if (ctl0[1:0] == 2'b11 && !ctl2[0] && len == MIN_LENGTH) begin
         k = KIND_U;
      end else if (ctl0[0] && !ctl2[0] && len == MIN_LENGTH) begin
         k = KIND_S;
      end else if (!ctl0[0] && !ctl2[0] && len > MIN_LENGTH) begin
         k = KIND_I;
      end else begin
         k = KIND_BAD;
      end
      return k;
   endfunction

endpackage

### hdl/iecd_front.sv
// Front end: byte parser, header buffer, frame classifier and sequence state.
// Emits one queue entry per item that causes results. Depends on iecd_pkg.
module iecd_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [1:0]                    req_type,
   input  logic [7:0]                    req_rx_byte,
   input  logic                          csr_wr_en,
   input  logic [7:0]                    csr_wr_data,
   output logic                          entry_push,
   output iecd_pkg::entry_type           entry
);

   iecd_pkg::phase_type          phase_ff, phase_in;
   logic [7:0]                   pos_ff, pos_in;
   logic [7:0]                   len_ff, len_in;
   logic [7:0]                   hdr_ff [iecd_pkg::HEADER_BYTES];
   logic [7:0]                   hdr_in [iecd_pkg::HEADER_BYTES];
   iecd_pkg::frame_kind_type     kind_ff, kind_in;
   logic [iecd_pkg::SEQ_W-1:0]   exp_ff, exp_in;
   logic [iecd_pkg::SEQ_W-1:0]   send_ff, send_in;
   logic [7:0]                   max_len_ff, max_len_in;

   logic                         is_byte;
   logic                         hdr_done;
   logic                         len_ok;
   iecd_pkg::frame_kind_type     hdr_kind;
   logic [iecd_pkg::SEQ_W-1:0]   rx_seq;
   logic                         repeat_frame;
   logic                         pass_last;

   assign is_byte   = accept && (req_type == iecd_pkg::REQ_BYTE);
   assign hdr_done  = (pos_ff == 8'(iecd_pkg::HEADER_BYTES - 1));
   assign len_ok    = (req_rx_byte >= iecd_pkg::MIN_LENGTH) && (req_rx_byte <= max_len_ff);
   assign hdr_kind  = iecd_pkg::classify(hdr_ff[2], hdr_ff[4], len_ff);
   assign rx_seq    = {hdr_ff[3], hdr_ff[2][7:1]};
   assign repeat_frame = (rx_seq < exp_ff);
   assign pass_last = (pos_ff <= 8'd1);

   // next parse phase
   always_comb begin
      phase_in = phase_ff;
      if (is_byte) begin
         unique case (phase_ff)
            iecd_pkg::PH_HUNT: begin
               if (req_rx_byte == iecd_pkg::START_BYTE) phase_in = iecd_pkg::PH_LEN;
            end
            iecd_pkg::PH_LEN: begin
               phase_in = len_ok ? iecd_pkg::PH_HDR : iecd_pkg::PH_HUNT;
            end
            iecd_pkg::PH_HDR: begin
               if (hdr_done) begin
                  if (hdr_kind == iecd_pkg::KIND_I) begin
                     phase_in = repeat_frame ? iecd_pkg::PH_SKIP : iecd_pkg::PH_PASS;
                  end else begin
                     phase_in = iecd_pkg::PH_HUNT;
                  end
               end
            end
            iecd_pkg::PH_PASS, iecd_pkg::PH_SKIP: begin
               if (pass_last) phase_in = iecd_pkg::PH_HUNT;
            end
            default: phase_in = iecd_pkg::PH_HUNT;
         endcase
      end
   end

   // datapath and queue entry
   always_comb begin
      pos_in     = pos_ff;
      len_in     = len_ff;
      hdr_in     = hdr_ff;
      kind_in    = kind_ff;
      exp_in     = exp_ff;
      send_in    = send_ff;
      max_len_in = csr_wr_en ? csr_wr_data : max_len_ff;
      entry_push = 1'b0;
      entry      = '0;
      entry.op   = iecd_pkg::ENTRY_BYTE;
      entry.kind = kind_ff;
      if (accept) begin
         unique case (req_type)
            iecd_pkg::REQ_STAMP_I: begin
               entry_push     = 1'b1;
               entry.op       = iecd_pkg::ENTRY_STAMP;
               entry.kind     = iecd_pkg::KIND_I;
               entry.last     = 1'b1;
               entry.send_seq = send_ff;
               entry.recv_seq = exp_ff;
               send_in        = send_ff + 15'd1;
            end
            iecd_pkg::REQ_STAMP_S: begin
               entry_push     = 1'b1;
               entry.op       = iecd_pkg::ENTRY_STAMP;
               entry.kind     = iecd_pkg::KIND_S;
               entry.last     = 1'b1;
               entry.recv_seq = exp_ff;
            end
            iecd_pkg::REQ_BYTE: begin
               unique case (phase_ff)
                  iecd_pkg::PH_HUNT: begin
                     hdr_in[0] = req_rx_byte;
                  end
                  iecd_pkg::PH_LEN: begin
                     if (len_ok) begin
                        hdr_in[1] = req_rx_byte;
                        len_in    = req_rx_byte;
                        pos_in    = 8'd2;
                     end
                  end
                  iecd_pkg::PH_HDR: begin
                     hdr_in[pos_ff[2:0]] = req_rx_byte;
                     if (!hdr_done) begin
                        pos_in = pos_ff + 8'd1;
                     end else if (hdr_kind == iecd_pkg::KIND_BAD) begin
                        pos_in = 8'd0;
                     end else begin
                        kind_in    = hdr_kind;
                        entry.op   = iecd_pkg::ENTRY_HEADER;
                        entry.kind = hdr_kind;
                        entry.data = {req_rx_byte, hdr_ff[4], hdr_ff[3],
                                      hdr_ff[2], hdr_ff[1], hdr_ff[0]};
                        if (hdr_kind == iecd_pkg::KIND_I) begin
                           pos_in = len_ff - iecd_pkg::MIN_LENGTH;
                           if (!repeat_frame) begin
                              exp_in     = exp_ff + 15'd1;
                              entry_push = 1'b1;
                           end
                        end else begin
                           pos_in     = 8'd0;
                           entry.last = 1'b1;
                           entry_push = 1'b1;
                        end
                     end
                  end
                  iecd_pkg::PH_PASS: begin
                     entry_push      = 1'b1;
                     entry.data[7:0] = req_rx_byte;
                     entry.last      = pass_last;
                     pos_in          = pass_last ? 8'd0 : pos_ff - 8'd1;
                  end
                  iecd_pkg::PH_SKIP: begin
                     pos_in = pass_last ? 8'd0 : pos_ff - 8'd1;
                  end
                  default: pos_in = 8'd0;
               endcase
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= iecd_pkg::PH_HUNT;
         pos_ff     <= 8'd0;
         len_ff     <= 8'd0;
         kind_ff    <= iecd_pkg::KIND_U;
         exp_ff     <= '0;
         send_ff    <= '0;
         max_len_ff <= iecd_pkg::MAX_LENGTH_INIT;
      end else begin
         phase_ff   <= phase_in;
         pos_ff     <= pos_in;
         len_ff     <= len_in;
         kind_ff    <= kind_in;
         exp_ff     <= exp_in;
         send_ff    <= send_in;
         max_len_ff <= max_len_in;
      end
   end

   always_ff @(posedge clock) begin
      hdr_ff <= hdr_in;
   end

endmodule

### hdl/iecd_fifo.sv
// Entry queue between the parser front end and the result back end.
// Show-ahead register queue of iecd_pkg::entry_type; depends on iecd_pkg.
module iecd_fifo #(
   parameter int DEPTH = iecd_pkg::FIFO_DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       wr_en,
   input  iecd_pkg::entry_type        wr_entry,
   input  logic                       rd_en,
   output iecd_pkg::entry_type        rd_entry,
   output iecd_pkg::fifo_status_type  status
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   iecd_pkg::entry_type  mem_ff [DEPTH];
   logic [AW-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]        count_ff, count_in;
   logic                 do_wr, do_rd;

   assign status.full  = (count_ff == CW'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_wr        = wr_en && !status.full;
   assign do_rd        = rd_en && !status.empty;
   assign rd_entry     = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + CW'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_entry;
      end
   end

endmodule

### hdl/iecd_back.sv
// Back end: expands queue entries into results and holds the result register.
// A header entry unrolls into six frame bytes. Depends on iecd_pkg.
module iecd_back (
   input  logic                          clock,
   input  logic                          reset,
   input  iecd_pkg::entry_type           rd_entry,
   input  logic                          fifo_empty,
   output logic                          fifo_pop,
   input  logic                          pop,
   output logic                          empty,
   output logic                          rsp_result_kind,
   output logic [7:0]                    rsp_frame_byte,
   output logic [1:0]                    rsp_frame_kind,
   output logic                          rsp_last_of_frame,
   output logic [iecd_pkg::SEQ_W-1:0]    rsp_stamp_send_seq,
   output logic [iecd_pkg::SEQ_W-1:0]    rsp_stamp_recv_seq
);

   localparam logic [2:0] LAST_IDX = 3'(iecd_pkg::HEADER_BYTES - 1);

   logic                         valid_ff, valid_in;
   logic [2:0]                   idx_ff, idx_in;
   logic                         load;
   logic                         is_hdr;
   logic                         rk_ff;
   logic [7:0]                   byte_ff, byte_in;
   logic [1:0]                   kind_ff;
   logic                         last_ff, last_in;
   logic [iecd_pkg::SEQ_W-1:0]   send_ff, recv_ff;

   assign load   = !fifo_empty && (!valid_ff || pop);
   assign is_hdr = (rd_entry.op == iecd_pkg::ENTRY_HEADER);

   always_comb begin
      idx_in   = idx_ff;
      fifo_pop = 1'b0;
      byte_in  = rd_entry.data[7:0];
      last_in  = rd_entry.last;
      valid_in = valid_ff && !pop;
      if (load) begin
         valid_in = 1'b1;
         if (is_hdr) begin
            byte_in  = rd_entry.data[{idx_ff, 3'b000} +: 8];
            last_in  = rd_entry.last && (idx_ff == LAST_IDX);
            fifo_pop = (idx_ff == LAST_IDX);
            idx_in   = (idx_ff == LAST_IDX) ? 3'd0 : idx_ff + 3'd1;
         end else begin
            fifo_pop = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 3'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rk_ff   <= (rd_entry.op == iecd_pkg::ENTRY_STAMP);
         byte_ff <= byte_in;
         kind_ff <= rd_entry.kind;
         last_ff <= last_in;
         send_ff <= rd_entry.send_seq;
         recv_ff <= rd_entry.recv_seq;
      end
   end

   assign empty              = !valid_ff;
   assign rsp_result_kind    = rk_ff;
   assign rsp_frame_byte     = byte_ff;
   assign rsp_frame_kind     = kind_ff;
   assign rsp_last_of_frame  = last_ff;
   assign rsp_stamp_send_seq = send_ff;
   assign rsp_stamp_recv_seq = recv_ff;

endmodule

### hdl/iec104_apci_deframer_seq.sv
// IEC 60870-5-104 APCI receive deframer with sequence stamping, top level.
// Joins iecd_front, iecd_fifo and iecd_back; depends on iecd_pkg.
//
// One request per cycle is accepted while full is low: a received link byte
// or a stamp request. The front end parses and classifies combinationally and
// writes at most one entry into a FIFO_DEPTH-entry queue; the back end drains
// one result per cycle into the output register while pop keeps it free. The
// byte ending a valid six-byte header yields one entry, unless the frame is a
// repeated I frame; that entry unrolls into six results, so full rises while
// such bursts back up and the output side is the bound on sustained rate: one
// result per cycle. max_apdu_length is written through csr_wr_en/csr_wr_data,
// resets to 253, and takes effect on the next byte.
module iec104_apci_deframer_seq #(
   parameter int FIFO_DEPTH = iecd_pkg::FIFO_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic [1:0]                    req_type,
   input  logic [7:0]                    req_rx_byte,
   output logic                          empty,
   input  logic                          pop,
   output logic                          rsp_result_kind,
   output logic [7:0]                    rsp_frame_byte,
   output logic [1:0]                    rsp_frame_kind,
   output logic                          rsp_last_of_frame,
   output logic [iecd_pkg::SEQ_W-1:0]    rsp_stamp_send_seq,
   output logic [iecd_pkg::SEQ_W-1:0]    rsp_stamp_recv_seq,
   input  logic                          csr_wr_en,
   input  logic [7:0]                    csr_wr_data
);

   logic                       accept;
   logic                       entry_push;
   logic                       fifo_pop;
   iecd_pkg::entry_type        wr_entry;
   iecd_pkg::entry_type        rd_entry;
   iecd_pkg::fifo_status_type  fifo_status;

   assign full   = fifo_status.full;
   assign accept = push && !fifo_status.full;

   iecd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req_type    (req_type),
      .req_rx_byte (req_rx_byte),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .entry_push  (entry_push),
      .entry       (wr_entry)
   );

   iecd_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (entry_push),
      .wr_entry (wr_entry),
      .rd_en    (fifo_pop),
      .rd_entry (rd_entry),
      .status   (fifo_status)
   );

   iecd_back u_back (
      .clock              (clock),
      .reset              (reset),
      .rd_entry           (rd_entry),
      .fifo_empty         (fifo_status.empty),
      .fifo_pop           (fifo_pop),
      .pop                (pop),
      .empty              (empty),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_frame_byte     (rsp_frame_byte),
      .rsp_frame_kind     (rsp_frame_kind),
      .rsp_last_of_frame  (rsp_last_of_frame),
      .rsp_stamp_send_seq (rsp_stamp_send_seq),
      .rsp_stamp_recv_seq (rsp_stamp_recv_seq)
   );

endmodule

### hdl/iecd_checker.sv
// Port-level checks for iec104_apci_deframer_seq, bound to the top level.
// Depends on iecd_pkg and the top level's port list.
module iecd_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          empty,
   input  logic                          pop,
   input  logic                          rsp_result_kind,
   input  logic [7:0]                    rsp_frame_byte,
   input  logic [1:0]                    rsp_frame_kind,
   input  logic                          rsp_last_of_frame,
   input  logic [iecd_pkg::SEQ_W-1:0]    rsp_stamp_send_seq,
   input  logic [iecd_pkg::SEQ_W-1:0]    rsp_stamp_recv_seq
);

   a_empty_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> empty)
      else $error("result visible right after reset");

   a_hold_while_waiting: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=>
         (!empty && $stable(rsp_result_kind) && $stable(rsp_frame_byte) &&
          $stable(rsp_frame_kind) && $stable(rsp_last_of_frame) &&
          $stable(rsp_stamp_send_seq) && $stable(rsp_stamp_recv_seq)))
      else $error("waiting result changed before transfer");

   a_stamp_shape: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_result_kind) |->
         (rsp_last_of_frame && rsp_frame_byte == 8'd0 &&
          (rsp_frame_kind == iecd_pkg::KIND_I || rsp_frame_kind == iecd_pkg::KIND_S)))
      else $error("malformed stamp answer");

   a_s_stamp_no_send: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_result_kind && rsp_frame_kind == iecd_pkg::KIND_S) |->
         (rsp_stamp_send_seq == '0))
      else $error("S stamp carries a send number");

   a_byte_no_seq: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_result_kind) |->
         (rsp_stamp_send_seq == '0 && rsp_stamp_recv_seq == '0 &&
          rsp_frame_kind != iecd_pkg::KIND_BAD))
      else $error("frame byte carries stamp fields or bad kind");

endmodule

bind iec104_apci_deframer_seq iecd_checker u_checker (.*);
